// ===== src/shfd_pkg.sv =====
// Shared types and constants for the sync header frame deframer.
// No dependencies; used by shfd_parser and sync_header_frame_deframer.
package shfd_pkg;

    // Header and frame geometry
    localparam int HEADER_LEN_DEFAULT = 6;
    localparam int HEADER_W           = 48;
    localparam int MATCH_W            = 3;
    localparam int POS_W              = 4;
    localparam logic [POS_W-1:0] PAYLOAD_LAST = 4'd9;

    // Separator byte expected after the type byte while hunting
    localparam logic [7:0] SEPARATOR_BYTE = 8'h2C;

    // Header word after reset
    localparam logic [HEADER_W-1:0] HEADER_RESET = 48'h43484952532C;

    // Result status codes
    localparam logic [1:0] STATUS_RECORD   = 2'd0;
    localparam logic [1:0] STATUS_BAD_SEP  = 2'd1;
    localparam logic [1:0] STATUS_HDR_MISS = 2'd2;

    // Parser modes
    localparam logic [1:0] MODE_HUNT     = 2'd0;
    localparam logic [1:0] MODE_CAPTURE  = 2'd1;
    localparam logic [1:0] MODE_SYNC_HDR = 2'd2;
    localparam logic [1:0] MODE_SYNC_PAY = 2'd3;

    // One result word from the parser
    typedef struct packed {
        logic        valid;
        logic [1:0]  status;
        logic [7:0]  rec_type;
        logic [31:0] source;
        logic [31:0] value;
        logic        synced;
    } result_t;

endpackage

// ===== src/shfd_parser.sv =====
// Byte-at-a-time frame parser: header hunt, payload capture, synced framing.
// Depends on shfd_pkg.
module shfd_parser #(
    parameter int HEADER_LEN = shfd_pkg::HEADER_LEN_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          step,
    input  logic [7:0]                    rx_byte,
    input  logic [shfd_pkg::HEADER_W-1:0] header_word,
    output shfd_pkg::result_t             result
);

    localparam logic [shfd_pkg::MATCH_W-1:0] LAST_IDX = shfd_pkg::MATCH_W'(HEADER_LEN - 1);

    logic [1:0]                   mode_reg, mode_next;
    logic [shfd_pkg::MATCH_W-1:0] match_count_reg, match_count_next;
    logic [shfd_pkg::POS_W-1:0]   frame_pos_reg, frame_pos_next;
    logic                         header_bad_reg, header_bad_next;
    logic [7:0]                   type_reg, type_next;
    logic [7:0]                   sep_reg, sep_next;
    logic [31:0]                  source_reg, source_next;
    logic [31:0]                  value_reg, value_next;

    logic [63:0]                  header_wide;
    logic [2:0]                   byte_idx;
    logic [7:0]                   expected;
    logic                         hdr_match;
    logic                         pay_last;

    // Expected header byte: first byte sits in the most significant used lane
    assign header_wide = {{(64 - shfd_pkg::HEADER_W){1'b0}}, header_word};
    assign byte_idx    = LAST_IDX - match_count_reg;
    assign expected    = header_wide[{byte_idx, 3'b000} +: 8];
    assign hdr_match   = (rx_byte == expected);
    assign pay_last    = (frame_pos_reg == shfd_pkg::PAYLOAD_LAST);

    // Payload byte lanes
    always_comb
    begin
        type_next   = type_reg;
        sep_next    = sep_reg;
        source_next = source_reg;
        value_next  = value_reg;
        if (mode_reg[0])
        begin
            case (frame_pos_reg)
                4'd0:    type_next          = rx_byte;
                4'd1:    sep_next           = rx_byte;
                4'd2:    source_next[7:0]   = rx_byte;
                4'd3:    source_next[15:8]  = rx_byte;
                4'd4:    source_next[23:16] = rx_byte;
                4'd5:    source_next[31:24] = rx_byte;
                4'd6:    value_next[7:0]    = rx_byte;
                4'd7:    value_next[15:8]   = rx_byte;
                4'd8:    value_next[23:16]  = rx_byte;
                4'd9:    value_next[31:24]  = rx_byte;
                default: type_next          = type_reg;
            endcase
        end
    end

    // Mode sequencing and result decision
    always_comb
    begin
        mode_next        = mode_reg;
        match_count_next = match_count_reg;
        frame_pos_next   = frame_pos_reg;
        header_bad_next  = header_bad_reg;
        result           = '0;

        unique case (mode_reg)
            shfd_pkg::MODE_HUNT:
            begin
                if (hdr_match)
                begin
                    if (match_count_reg == LAST_IDX)
                    begin
                        match_count_next = '0;
                        frame_pos_next   = '0;
                        mode_next        = shfd_pkg::MODE_CAPTURE;
                    end
                    else
                    begin
                        match_count_next = match_count_reg + 1'b1;
                    end
                end
                else
                begin
                    match_count_next = '0;
                end
            end

            shfd_pkg::MODE_CAPTURE:
            begin
                frame_pos_next = frame_pos_reg + 1'b1;
                if (pay_last)
                begin
                    frame_pos_next   = '0;
                    match_count_next = '0;
                    result.valid     = 1'b1;
                    if (sep_next != shfd_pkg::SEPARATOR_BYTE)
                    begin
                        mode_next     = shfd_pkg::MODE_HUNT;
                        result.status = shfd_pkg::STATUS_BAD_SEP;
                    end
                    else
                    begin
                        mode_next       = shfd_pkg::MODE_SYNC_HDR;
                        header_bad_next = 1'b0;
                        result.status   = shfd_pkg::STATUS_RECORD;
                        result.rec_type = type_next;
                        result.source   = source_next;
                        result.value    = value_next;
                        result.synced   = 1'b1;
                    end
                end
            end

            shfd_pkg::MODE_SYNC_HDR:
            begin
                // every header byte is consumed; a miss only marks the frame
                if (!hdr_match)
                    header_bad_next = 1'b1;
                if (match_count_reg == LAST_IDX)
                begin
                    match_count_next = '0;
                    frame_pos_next   = '0;
                    mode_next        = shfd_pkg::MODE_SYNC_PAY;
                end
                else
                begin
                    match_count_next = match_count_reg + 1'b1;
                end
            end

            shfd_pkg::MODE_SYNC_PAY:
            begin
                frame_pos_next = frame_pos_reg + 1'b1;
                if (pay_last)
                begin
                    frame_pos_next   = '0;
                    match_count_next = '0;
                    result.valid     = 1'b1;
                    if (header_bad_reg)
                    begin
                        header_bad_next = 1'b0;
                        mode_next       = shfd_pkg::MODE_HUNT;
                        result.status   = shfd_pkg::STATUS_HDR_MISS;
                    end
                    else
                    begin
                        mode_next       = shfd_pkg::MODE_SYNC_HDR;
                        result.status   = shfd_pkg::STATUS_RECORD;
                        result.rec_type = type_next;
                        result.source   = source_next;
                        result.value    = value_next;
                        result.synced   = 1'b1;
                    end
                end
            end

            default:
            begin
                mode_next = shfd_pkg::MODE_HUNT;
            end
        endcase

        if (!step)
            result.valid = 1'b0;
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= shfd_pkg::MODE_HUNT;
            match_count_reg <= '0;
            frame_pos_reg   <= '0;
            header_bad_reg  <= 1'b0;
        end
        else if (step)
        begin
            mode_reg        <= mode_next;
            match_count_reg <= match_count_next;
            frame_pos_reg   <= frame_pos_next;
            header_bad_reg  <= header_bad_next;
        end
    end

    // Payload capture
    always_ff @(posedge clk)
    begin
        if (step)
        begin
            type_reg   <= type_next;
            sep_reg    <= sep_next;
            source_reg <= source_next;
            value_reg  <= value_next;
        end
    end

endmodule

// ===== src/sync_header_frame_deframer.sv =====
// Top level of the sync header frame deframer: input and result registers,
// header register and the parser. Depends on shfd_pkg and shfd_parser.
//
// Takes one received byte per word and emits a record or an error word at the
// end of each frame. A byte can be accepted every clock cycle while in_stall is
// low; an accepted byte passes an input register and the parser, and its
// result (if any) is then registered in the result register. The input side
// stalls only while the input register holds a byte and the result register
// is full and stalled. The header register is written through the cfg port,
// which is always ready; write it only while the block is idle.
module sync_header_frame_deframer #(
    parameter int HEADER_LEN = shfd_pkg::HEADER_LEN_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // byte input
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [7:0]                    rx_byte,
    // result output
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [1:0]                    status,
    output logic [7:0]                    record_type,
    output logic [31:0]                   record_source,
    output logic [31:0]                   record_value,
    output logic                          is_synced,
    // header register write
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [shfd_pkg::HEADER_W-1:0] header_word
);

    logic                          in_valid_reg;
    logic [7:0]                    in_byte_reg;
    logic [shfd_pkg::HEADER_W-1:0] header_reg;
    logic                          out_valid_reg;
    shfd_pkg::result_t             out_reg;
    shfd_pkg::result_t             result;
    logic                          out_free;
    logic                          step;

    // Handshake
    assign out_free  = !out_valid_reg || !out_stall;
    assign step      = in_valid_reg && out_free;
    assign in_stall  = in_valid_reg && !out_free;
    assign cfg_ready = 1'b1;

    // Header register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            header_reg <= shfd_pkg::HEADER_RESET;
        else if (cfg_valid)
            header_reg <= header_word;
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_valid && !in_stall)
            in_valid_reg <= 1'b1;
        else if (step)
            in_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
            in_byte_reg <= rx_byte;
    end

    // Parser
    shfd_parser #(
        .HEADER_LEN (HEADER_LEN)
    ) u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .rx_byte     (in_byte_reg),
        .header_word (header_reg),
        .result      (result)
    );

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (result.valid)
            out_valid_reg <= 1'b1;
        else if (out_free)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (result.valid)
            out_reg <= result;
    end

    assign out_valid     = out_valid_reg;
    assign status        = out_reg.status;
    assign record_type   = out_reg.rec_type;
    assign record_source = out_reg.source;
    assign record_value  = out_reg.value;
    assign is_synced     = out_reg.synced;

endmodule

// ===== tb/sync_header_frame_deframer_tb.sv =====
// Self-checking testbench for sync_header_frame_deframer: byte stream in,
// record and error words out. Depends on shfd_pkg and the block's RTL only.
`timescale 1ns / 100ps

// One expected or observed result word
typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  rtype;
    logic [31:0] source;
    logic [31:0] value;
    logic        synced;
} frame_result_t;

// Frame parser prediction plus queue of frame results still to come
class frame_scoreboard;
    localparam int unsigned HDR_LEN = shfd_pkg::HEADER_LEN_DEFAULT;

    logic [shfd_pkg::HEADER_W-1:0] hdr_word;
    logic [1:0]          mode;
    int unsigned         match_idx;
    int unsigned         pay_idx;
    bit                  hdr_bad;
    logic [7:0]          type_b;
    logic [7:0]          sep_b;
    logic [31:0]         src_w;
    logic [31:0]         val_w;
    frame_result_t       frames_due[$];
    int unsigned         fail_count;

    function new();
        hdr_word   = shfd_pkg::HEADER_RESET;
        mode       = shfd_pkg::MODE_HUNT;
        match_idx  = 0;
        hdr_bad    = 0;
        fail_count = 0;
        clear_fields();
    endfunction

    function int unsigned pending();
        return frames_due.size();
    endfunction

    function void set_header(logic [shfd_pkg::HEADER_W-1:0] w);
        hdr_word = w;
    endfunction

    // header byte i, first received byte in the top used position
    function logic [7:0] hdr_byte(int unsigned i);
        int unsigned sh;
        if (i >= HDR_LEN)
            return 8'h00;
        sh = 8 * (HDR_LEN - 1 - i);
        if (sh >= shfd_pkg::HEADER_W)
            return 8'h00;
        return hdr_word[sh +: 8];
    endfunction

    function void clear_fields();
        pay_idx = 0;
        type_b  = '0;
        sep_b   = '0;
        src_w   = '0;
        val_w   = '0;
    endfunction

    // store one payload byte; 1 when the payload is complete
    function bit take_field(logic [7:0] b);
        if (pay_idx == 0)
            type_b = b;
        else if (pay_idx == 1)
            sep_b = b;
        else if (pay_idx < 6)
            src_w[8*(pay_idx-2) +: 8] = b;
        else
            val_w[8*(pay_idx-6) +: 8] = b;
        if (pay_idx == shfd_pkg::PAYLOAD_LAST) begin
            pay_idx = 0;
            return 1'b1;
        end
        pay_idx++;
        return 1'b0;
    endfunction

    function void push_frame(logic [1:0] st, bit rec);
        frame_result_t r;
        r.status = st;
        r.rtype  = rec ? type_b : 8'h00;
        r.source = rec ? src_w : 32'h0;
        r.value  = rec ? val_w : 32'h0;
        r.synced = rec;
        frames_due.push_back(r);
    endfunction

    function void flag(string msg);
        fail_count++;
        if (fail_count <= 10)
            $display("%s", msg);
    endfunction

    // advance the parser by one accepted byte
    function void note_byte(logic [7:0] b);
        case (mode)
            shfd_pkg::MODE_HUNT: begin
                // a mismatching byte is not retried as a first header byte
                if (b == hdr_byte(match_idx)) begin
                    match_idx++;
                    if (match_idx >= HDR_LEN) begin
                        match_idx = 0;
                        clear_fields();
                        mode = shfd_pkg::MODE_CAPTURE;
                    end
                end else begin
                    match_idx = 0;
                end
            end
            shfd_pkg::MODE_CAPTURE: begin
                if (take_field(b)) begin
                    match_idx = 0;
                    if (sep_b != shfd_pkg::SEPARATOR_BYTE) begin
                        mode = shfd_pkg::MODE_HUNT;
                        push_frame(shfd_pkg::STATUS_BAD_SEP, 1'b0);
                    end else begin
                        mode    = shfd_pkg::MODE_SYNC_HDR;
                        hdr_bad = 1'b0;
                        push_frame(shfd_pkg::STATUS_RECORD, 1'b1);
                    end
                end
            end
            shfd_pkg::MODE_SYNC_HDR: begin
                if (b != hdr_byte(match_idx))
                    hdr_bad = 1'b1;
                match_idx++;
                if (match_idx >= HDR_LEN) begin
                    match_idx = 0;
                    clear_fields();
                    mode = shfd_pkg::MODE_SYNC_PAY;
                end
            end
            default: begin
                // synced payload: separator captured, never checked
                if (take_field(b)) begin
                    match_idx = 0;
                    if (hdr_bad) begin
                        hdr_bad = 1'b0;
                        mode    = shfd_pkg::MODE_HUNT;
                        push_frame(shfd_pkg::STATUS_HDR_MISS, 1'b0);
                    end else begin
                        mode = shfd_pkg::MODE_SYNC_HDR;
                        push_frame(shfd_pkg::STATUS_RECORD, 1'b1);
                    end
                end
            end
        endcase
    endfunction

    function void check_frame(frame_result_t got);
        frame_result_t want;
        if (frames_due.size() == 0) begin
            flag($sformatf("unexpected result: st=%0d type=%h src=%h val=%h sync=%b",
                           got.status, got.rtype, got.source, got.value, got.synced));
            return;
        end
        want = frames_due.pop_front();
        if (got.status !== want.status || got.rtype !== want.rtype ||
            got.source !== want.source || got.value !== want.value ||
            got.synced !== want.synced)
            flag($sformatf({"result mismatch: exp st=%0d type=%h src=%h val=%h sync=%b",
                            " / got st=%0d type=%h src=%h val=%h sync=%b"},
                           want.status, want.rtype, want.source, want.value, want.synced,
                           got.status, got.rtype, got.source, got.value, got.synced));
    endfunction
endclass

module sync_header_frame_deframer_tb;

    logic                clk;
    logic                rst_n         = 1'b0;
    logic                in_valid      = 1'b0;
    logic                in_stall;
    logic [7:0]          rx_byte       = 8'h00;
    logic                out_valid;
    logic                out_stall     = 1'b0;
    logic [1:0]          status;
    logic [7:0]          record_type;
    logic [31:0]         record_source;
    logic [31:0]         record_value;
    logic                is_synced;
    logic                cfg_valid     = 1'b0;
    logic                cfg_ready;
    logic [shfd_pkg::HEADER_W-1:0] header_word = shfd_pkg::HEADER_RESET;

    frame_scoreboard sb;
    int unsigned     send_idle_pct = 0;
    int unsigned     recv_stall_pct = 0;
    int unsigned     bytes_sent = 0;

    sync_header_frame_deframer dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .rx_byte       (rx_byte),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .status        (status),
        .record_type   (record_type),
        .record_source (record_source),
        .record_value  (record_value),
        .is_synced     (is_synced),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .header_word   (header_word)
    );

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // watchdog
    initial begin
        #10_000_000;
        $display("** sync_header_frame_deframer: FAILED **");
        $finish;
    end

    // result side: random stall, check every word taken
    initial begin
        frame_result_t got;
        forever begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall) begin
                got.status = status;
                got.rtype  = record_type;
                got.source = record_source;
                got.value  = record_value;
                got.synced = is_synced;
                sb.check_frame(got);
            end
            out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // push one byte through the input handshake, with random idle cycles first
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_byte(b);
        bytes_sent++;
    endtask

    // drain all frame results, then write the header register
    task automatic write_header(input logic [shfd_pkg::HEADER_W-1:0] w);
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        // a trailing byte that makes no result may still be in the pipe
        repeat (6) @(posedge clk);
        cfg_valid   <= 1'b1;
        header_word <= w;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        sb.set_header(w);
    endtask

    // byte biased toward the field extremes
    function automatic logic [7:0] pick_byte();
        case ($urandom_range(9))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    task automatic send_header(input int bad_at);
        logic [7:0] b;
        for (int i = 0; i < shfd_pkg::HEADER_LEN_DEFAULT; i++) begin
            b = sb.hdr_byte(i);
            if (i == bad_at)
                b = b ^ 8'($urandom_range(255, 1));
            send_byte(b);
        end
    endtask

    task automatic send_payload(input logic [7:0] ftype, input logic [7:0] sep);
        send_byte(ftype);
        send_byte(sep);
        repeat (8) send_byte(pick_byte());
    endtask

    // well-formed sequences with random content, plus noise and broken frames
    task automatic random_traffic(input int unsigned n_bytes);
        int unsigned stop_at;
        int unsigned k;
        logic [7:0]  sep;
        logic [7:0]  ftype;
        stop_at = bytes_sent + n_bytes;
        while (bytes_sent < stop_at) begin
            // leading noise, sometimes a header prefix cut short
            if ($urandom_range(3) == 0) begin
                k = $urandom_range(shfd_pkg::HEADER_LEN_DEFAULT - 1);
                for (int i = 0; i < k; i++)
                    send_byte(sb.hdr_byte(i));
            end
            repeat ($urandom_range(4)) send_byte(pick_byte());
            // hunted frame, separator usually good
            sep = shfd_pkg::SEPARATOR_BYTE;
            if ($urandom_range(99) < 15)
                sep = 8'($urandom_range(255)) ^ 8'h80;
            ftype = ($urandom_range(2) == 0) ? 8'h54 : pick_byte();
            send_header(-1);
            send_payload(ftype, sep);
            if (sep != shfd_pkg::SEPARATOR_BYTE)
                continue;
            // run of synced frames; any separator, header sometimes broken
            k = $urandom_range(6, 1);
            for (int f = 0; f < k; f++) begin
                if ($urandom_range(99) < 12) begin
                    send_header($urandom_range(shfd_pkg::HEADER_LEN_DEFAULT - 1));
                    send_payload(pick_byte(), pick_byte());
                    break;
                end
                send_header(-1);
                sep = ($urandom_range(1) == 0) ? shfd_pkg::SEPARATOR_BYTE : pick_byte();
                send_payload(($urandom_range(1) == 0) ? 8'h48 : pick_byte(), sep);
            end
        end
    endtask

    initial begin
        sb = new();
        send_idle_pct  = 18;
        recv_stall_pct = 60;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset header, extremes of source and value
        write_header(shfd_pkg::HEADER_RESET);
        // repeated first header byte: the second one is not retried
        send_byte(sb.hdr_byte(0));
        send_byte(sb.hdr_byte(0));
        send_header(-1);
        send_byte(8'h54);
        send_byte(shfd_pkg::SEPARATOR_BYTE);
        send_byte(8'h00); send_byte(8'hFF); send_byte(8'h00); send_byte(8'hFF);
        send_byte(8'hFF); send_byte(8'hFF); send_byte(8'hFF); send_byte(8'hFF);
        // synced frame, separator not checked
        send_header(-1);
        send_byte(8'h48);
        send_byte(8'h00);
        send_byte(8'h78); send_byte(8'h56); send_byte(8'h34); send_byte(8'h12);
        send_byte(8'h00); send_byte(8'h00); send_byte(8'h80); send_byte(8'h3F);
        // synced header mismatch on the last header byte
        send_header(shfd_pkg::HEADER_LEN_DEFAULT - 1);
        send_payload(8'h54, shfd_pkg::SEPARATOR_BYTE);
        // hunted frame with a bad separator
        send_header(-1);
        send_payload(8'h54, 8'hFF);

        random_traffic(560);

        // sender busy, receiver mostly ready; header extremes
        send_idle_pct  = 60;
        recv_stall_pct = 18;
        write_header('0);
        random_traffic(280);
        write_header('1);
        random_traffic(280);

        // no idling on either side, random header
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        write_header({16'($urandom), 32'($urandom)});
        random_traffic(560);

        // drain and let the pipe settle
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (sb.fail_count == 0)
            $display("** sync_header_frame_deframer: PASSED **");
        else
            $display("** sync_header_frame_deframer: FAILED **");
        $finish;
    end

endmodule
